// ===== rtl/core/itrt_pkg.sv =====
`timescale 1ns / 1ps

package itrt_pkg;

    // Alphabet geometry
    localparam int ALPHA_MAX   = 64;
    localparam int ALPHA_REGS  = 8;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;   // digit value 0..63
    localparam int RADIX_W     = 7;   // alphabet length 0..64
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DIG_LO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIG_HI  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPR_LO  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPR_HI  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LWR_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LWR_HI  = 8'h7A;

    // Alphabet storage, character 0 in element 0
    typedef logic [ALPHA_MAX-1:0][CHAR_W-1:0] alpha_vec_t;

    // Alphabet check status handed to the front and back parts
    typedef struct packed {
        logic               busy;
        logic               ok;
        logic [RADIX_W-1:0] radix;
    } alpha_stat_t;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return c inside {[CHAR_DIG_LO:CHAR_DIG_HI], [CHAR_UPR_LO:CHAR_UPR_HI],
                         [CHAR_LWR_LO:CHAR_LWR_HI]};
    endfunction

endpackage

// ===== rtl/core/integer_to_radix_text.sv =====
`timescale 1ns / 1ps

// Signed integer to text in the radix of a configured alphabet.
// cfg channel: cfg_index selects one of eight 64-bit alphabet registers
// (characters 8*i..8*i+7, lowest byte first, first zero byte ends the
// alphabet); cfg_ready is always high. Each write starts a check sweep over
// up to 64 characters (one character per cycle) during which s_tready is low.
// s channel: one signed number per transaction. Under an invalid alphabet
// (shorter than two, non-alphanumeric, or a repeated character) the number
// is taken and produces nothing.
// m channel: one character per transaction, '-' first for negatives, then
// digits most significant first; m_tlast marks the final digit.
// Conversion: the number is dequeued, then the division unit works out each
// digit through the NCH bytes of the dividend (NCH = ceil(NUMBER_WIDTH/8),
// four at 32 bits, eight quotient bits per cycle); a fetch state also sends
// the minus sign of a negative number, then the digits go out while m_tready allows.
// A two-entry queue sits between the input stage and the divider, so two
// more numbers are taken while one is converted. Reset clears the alphabet
// (invalid) and all control; a stalled m_tready holds the output register
// and stops the converter, and the queue then fills and drops s_tready.
module integer_to_radix_text #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]  s_tdata,    // value_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [itrt_pkg::CHAR_W-1:0]        m_tdata,    // text_char
    output logic                               m_tlast,    // last_char
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [itrt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [itrt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import itrt_pkg::*;

    alpha_vec_t              alpha;
    alpha_stat_t             stat;
    logic                    q_full;
    logic                    push;
    logic [NUMBER_WIDTH:0]   push_data;
    logic                    pop;
    logic                    q_valid;
    logic [NUMBER_WIDTH:0]   pop_data;

    itrt_alpha_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .alpha     (alpha),
        .stat      (stat)
    );

    itrt_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .stat      (stat),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    itrt_queue #(.WIDTH(NUMBER_WIDTH + 1)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_data  (pop_data)
    );

    itrt_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .alpha     (alpha),
        .radix     (stat.radix),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/core/itrt_alpha_check.sv =====
`timescale 1ns / 1ps

module itrt_alpha_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [itrt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [itrt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output itrt_pkg::alpha_vec_t              alpha,
    output itrt_pkg::alpha_stat_t             stat
);
    import itrt_pkg::*;

    alpha_vec_t          alpha_reg;
    logic                busy_reg;
    logic                ok_reg;
    logic                acc_ok_reg;
    logic [RADIX_W-1:0]  radix_reg;
    logic [RADIX_W-1:0]  scan_reg;

    logic [CHAR_W-1:0]   scan_char;
    logic                scan_end;
    logic                dup;

    assign cfg_ready = 1'b1;
    assign alpha     = alpha_reg;
    assign stat      = '{busy: busy_reg, ok: ok_reg, radix: radix_reg};

    // Current scan character and duplicate search against earlier positions
    always_comb
    begin
        scan_char = alpha_reg[scan_reg[DIGIT_W-1:0]];
        scan_end  = scan_reg[RADIX_W-1] || (scan_char == CHAR_NUL);
        dup       = 1'b0;
        for (int j = 0; j < ALPHA_MAX; j++)
        begin
            if ((RADIX_W'(j) < scan_reg) && (alpha_reg[j] == scan_char))
                dup = 1'b1;
        end
    end

    // Register file and check sweep, one character per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= '0;
            busy_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            acc_ok_reg <= 1'b0;
            radix_reg  <= '0;
            scan_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index < CFG_INDEX_W'(ALPHA_REGS))
                alpha_reg[{cfg_index[2:0], 3'b000} +: 8] <= cfg_data;
            busy_reg   <= 1'b1;
            ok_reg     <= 1'b0;
            acc_ok_reg <= 1'b1;
            scan_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (scan_end)
            begin
                busy_reg  <= 1'b0;
                ok_reg    <= acc_ok_reg && (scan_reg >= RADIX_W'(2));
                radix_reg <= scan_reg;
            end
            else
            begin
                if (!is_alnum(scan_char) || dup)
                    acc_ok_reg <= 1'b0;
                scan_reg <= scan_reg + RADIX_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/itrt_front.sv =====
`timescale 1ns / 1ps

module itrt_front #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]      s_tdata,
    input  itrt_pkg::alpha_stat_t                  stat,
    input  logic                                   q_full,
    output logic                                   push,
    output logic [NUMBER_WIDTH:0]                  push_data   // {neg, magnitude}
);
    import itrt_pkg::*;

    logic [NUMBER_WIDTH-1:0] value;
    logic                    neg;
    logic [NUMBER_WIDTH-1:0] mag;

    // Hold off while the alphabet is being checked or the queue is full
    assign s_tready = !stat.busy && !q_full;

    // Sign and magnitude; the most negative value maps to 2^(W-1) unsigned
    always_comb
    begin
        value     = s_tdata[NUMBER_WIDTH-1:0];
        neg       = value[NUMBER_WIDTH-1];
        mag       = neg ? (~value + NUMBER_WIDTH'(1)) : value;
        push_data = {neg, mag};
        // Items under an invalid alphabet are dropped here
        push      = s_tvalid && s_tready && stat.ok;
    end

endmodule

// ===== rtl/core/itrt_queue.sv =====
`timescale 1ns / 1ps

module itrt_queue #(
    parameter int WIDTH = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Two-entry ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/itrt_back.sv =====
`timescale 1ns / 1ps

module itrt_back #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [NUMBER_WIDTH:0]               q_data,    // {neg, magnitude}
    output logic                                q_pop,
    input  itrt_pkg::alpha_vec_t                alpha,
    input  logic [itrt_pkg::RADIX_W-1:0]        radix,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [itrt_pkg::CHAR_W-1:0]         m_tdata,
    output logic                                m_tlast
);
    import itrt_pkg::*;

    localparam int CHUNK  = 8;
    localparam int NCH    = (NUMBER_WIDTH + CHUNK - 1) / CHUNK;
    localparam int PAD_W  = NCH * CHUNK;
    localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int DIG_AW = $clog2(NUMBER_WIDTH);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FETCH, ST_EMIT} state_t;

    state_t              state_reg;
    logic [PAD_W-1:0]    div_reg;
    logic [RADIX_W-1:0]  rem_reg;
    logic [CH_W-1:0]     chunk_reg;
    logic [DIG_AW-1:0]   dcnt_reg;
    logic [DIG_AW-1:0]   idx_reg;
    logic                neg_reg;
    logic                m_tvalid_reg;
    logic [CHAR_W-1:0]   m_tdata_reg;
    logic                m_tlast_reg;

    // Digit store, least significant digit at address 0
    logic [DIGIT_W-1:0]  dig_mem [NUMBER_WIDTH];
    logic [DIGIT_W-1:0]  mem_q_reg;
    logic [DIG_AW-1:0]   rd_addr;

    logic [RADIX_W-1:0]  rem_next;
    logic [CHUNK-1:0]    qbits;
    logic [PAD_W-1:0]    div_next;
    logic [CHUNK:0]      trial;
    logic                last_chunk;
    logic                out_free;
    logic                emit;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_chunk = (chunk_reg == CH_W'(NCH - 1));

    // A new character is loaded into the output register this cycle
    assign emit = out_free && (((state_reg == ST_FETCH) && neg_reg) || (state_reg == ST_EMIT));

    // Eight restoring division steps on the top byte of the dividend
    always_comb
    begin
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int b = 0; b < CHUNK; b++)
        begin
            trial = {1'b0, rem_next, div_reg[PAD_W-1-b]};
            if (trial >= (CHUNK+1)'(radix))
            begin
                rem_next           = RADIX_W'(trial - (CHUNK+1)'(radix));
                qbits[CHUNK-1-b]   = 1'b1;
            end
            else
                rem_next = trial[RADIX_W-1:0];
        end
        div_next = (div_reg << CHUNK) | PAD_W'(qbits);
    end

    // Read address runs one digit ahead while characters go out
    always_comb
    begin
        if ((state_reg == ST_EMIT) && out_free && (idx_reg != '0))
            rd_addr = idx_reg - DIG_AW'(1);
        else
            rd_addr = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV) && last_chunk)
            dig_mem[dcnt_reg] <= rem_next[DIGIT_W-1:0];
        mem_q_reg <= dig_mem[rd_addr];
    end

    // Sequencer: divide down to zero, then emit sign and digits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            div_reg      <= '0;
            rem_reg      <= '0;
            chunk_reg    <= '0;
            dcnt_reg     <= '0;
            idx_reg      <= '0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            // Output valid: set on a new character, cleared once taken
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        div_reg   <= PAD_W'(q_data[NUMBER_WIDTH-1:0]);
                        neg_reg   <= q_data[NUMBER_WIDTH];
                        rem_reg   <= '0;
                        chunk_reg <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    div_reg <= div_next;
                    if (last_chunk)
                    begin
                        rem_reg   <= '0;
                        chunk_reg <= '0;
                        if (div_next == '0)
                        begin
                            idx_reg   <= dcnt_reg;
                            state_reg <= ST_FETCH;
                        end
                        else
                            dcnt_reg <= dcnt_reg + DIG_AW'(1);
                    end
                    else
                    begin
                        rem_reg   <= rem_next;
                        chunk_reg <= chunk_reg + CH_W'(1);
                    end
                end
                ST_FETCH:
                begin
                    if (!neg_reg)
                        state_reg <= ST_EMIT;
                    else if (out_free)
                    begin
                        m_tdata_reg  <= CHAR_MINUS;
                        m_tlast_reg  <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= alpha[mem_q_reg];
                        m_tlast_reg  <= (idx_reg == '0);
                        if (idx_reg == '0)
                            state_reg <= ST_IDLE;
                        else
                            idx_reg <= idx_reg - DIG_AW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/itrt_checker.sv =====
`timescale 1ns / 1ps

module itrt_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [itrt_pkg::CHAR_W-1:0]   m_tdata,
    input  logic                          m_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready
);
    import itrt_pkg::*;

    // Stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Every character is a minus sign or an alphanumeric digit
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CHAR_MINUS)
                  || (m_tdata >= CHAR_DIG_LO && m_tdata <= CHAR_DIG_HI)
                  || (m_tdata >= CHAR_UPR_LO && m_tdata <= CHAR_UPR_HI)
                  || (m_tdata >= CHAR_LWR_LO && m_tdata <= CHAR_LWR_HI))
        else $error("character outside alphabet set");

    // A sign never ends a number
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == CHAR_MINUS) |-> !m_tlast)
        else $error("minus sign flagged last");

    // A sign is followed by a digit, never another sign
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tdata == CHAR_MINUS)
        |=> !m_tvalid || (m_tdata != CHAR_MINUS))
        else $error("two minus signs in a row");

    // Input is held off while a new alphabet is checked
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input taken during alphabet check");

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import itrt_pkg::*;

    localparam int NUMBER_WIDTH  = 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 600;   // three numbers of 33 characters in flight
    localparam int HOLD_CYCLES   = 500;
    localparam int CFG_INDEX_TOP = 2 ** CFG_INDEX_W - 1;
    localparam string ALNUM_POOL =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_item_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // DUT ports
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [31:0]             s_tdata  = '0;    // value_in
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [CHAR_W-1:0]       m_tdata;          // text_char
    logic                    m_tlast;          // last_char
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // Testbench state
    logic [CFG_DATA_W-1:0]   alphabet_regs [ALPHA_REGS];
    logic [CFG_DATA_W-1:0]   next_regs     [ALPHA_REGS];
    logic [31:0]             pending_values [$];
    text_item_t              expected_text  [$];
    int                      tx_idle_pct  = 0;
    int                      rx_stall_pct = 0;
    bit                      pressure_start = 1'b0;
    logic                    rx_hold = 1'b0;
    int                      error_count = 0;
    int                      cycle_count = 0;

    integer_to_radix_text #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit char_is_alnum(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_DIG_LO && c <= CHAR_DIG_HI) ||
               (c >= CHAR_UPR_LO && c <= CHAR_UPR_HI) ||
               (c >= CHAR_LWR_LO && c <= CHAR_LWR_HI);
    endfunction

    // Expected characters for one number under the current alphabet
    function automatic void predict_text(input logic [31:0] value);
        logic [CHAR_W-1:0] chars  [ALPHA_MAX];
        bit                seen   [256];
        logic [5:0]        digits [NUMBER_WIDTH+1];
        logic [32:0]       mag;
        text_item_t        item;
        int                len;
        int                nd;
        bit                ok;
        len = 0;
        while (len < ALPHA_MAX && alphabet_regs[len/8][(len%8)*8 +: 8] != CHAR_NUL)
        begin
            chars[len] = alphabet_regs[len/8][(len%8)*8 +: 8];
            len++;
        end
        // alphabet check: length, character class, no repeats
        ok = (len >= 2);
        foreach (seen[i])
            seen[i] = 1'b0;
        for (int i = 0; i < len; i++)
        begin
            if (!char_is_alnum(chars[i]) || seen[chars[i]])
                ok = 1'b0;
            seen[chars[i]] = 1'b1;
        end
        if (!ok)
            return;
        // 33-bit magnitude covers the most negative value
        mag = value[31] ? (33'd0 - {1'b1, value}) : {1'b0, value};
        nd = 0;
        do
        begin
            digits[nd] = 6'(mag % 33'(len));
            mag = mag / 33'(len);
            nd++;
        end
        while (mag != 0);
        if (value[31])
        begin
            item.ch   = CHAR_MINUS;
            item.last = 1'b0;
            expected_text.push_back(item);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            item.ch   = chars[digits[i]];
            item.last = (i == 0);
            expected_text.push_back(item);
        end
    endfunction

    // Input driver: one number per transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                predict_text(s_tdata);
            if (pending_values.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_values.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output monitor and receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin : text_monitor
        text_item_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        error_count++;
                        $display("%0t: text_char mismatch: expected %h, actual %h",
                                 $time, want.ch, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off so the input queue fills and s_tready drops
    initial
    begin : receiver_hold
        wait (pressure_start);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // One register write transaction; valid is left high for back-to-back writes
    task automatic write_cfg(input int idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_W'(idx);
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < ALPHA_REGS)
            alphabet_regs[idx] = data;
    endtask

    task automatic load_alphabet();
        for (int r = 0; r < ALPHA_REGS; r++)
            write_cfg(r, next_regs[r]);
        cfg_valid <= 1'b0;
    endtask

    // Pack a string into the register image; optional junk after the terminator
    function automatic void set_alphabet(input string s, input bit junk);
        for (int r = 0; r < ALPHA_REGS; r++)
            next_regs[r] = '0;
        for (int i = 0; i < s.len() && i < ALPHA_MAX; i++)
            next_regs[i/8][(i%8)*8 +: 8] = s[i];
        if (junk)
            for (int i = s.len() + 1; i < ALPHA_MAX; i++)
                next_regs[i/8][(i%8)*8 +: 8] = CHAR_W'($urandom_range(255));
    endfunction

    function automatic string random_alphabet(input int len);
        string s;
        byte   tmp;
        int    j;
        s = ALNUM_POOL;
        for (int i = 0; i < s.len() - 1; i++)
        begin
            j = $urandom_range(s.len() - 1, i);
            tmp = s[i];
            s[i] = s[j];
            s[j] = tmp;
        end
        return s.substr(0, len - 1);
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(9))
            5: return $urandom_range(100);
            6: return -$urandom_range(100);
            7:
            begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            8: return ($urandom_range(1) ? -1 : 1) * (32'd1 << $urandom_range(30));
            default: return $urandom;
        endcase
    endfunction

    // Idle settings change away from the clock edge
    task automatic start_phase(input int tx_pct, input int rx_pct);
        @(negedge clk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic wait_block_idle();
        do
            @(posedge clk);
        while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Phase sequencer
    initial
    begin : sequencer
        string alpha;
        for (int r = 0; r < ALPHA_REGS; r++)
            alphabet_regs[r] = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty alphabet after reset: numbers are taken, nothing comes out
        start_phase(0, 0);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back($urandom);
        wait_block_idle();

        // decimal, junk bytes past the terminator
        set_alphabet("0123456789", 1'b1);
        load_alphabet();
        start_phase(0, 0);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(-32'd10);
        pending_values.push_back(32'd100);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'd123456789);
        pending_values.push_back(-32'd987654321);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'h5555_5555);
        wait_block_idle();

        // shortest alphabet: binary, longest digit strings
        set_alphabet("01", 1'b0);
        load_alphabet();
        start_phase(66, 0);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'd2);
        wait_block_idle();

        // largest valid alphabet: all 62 alphanumerics
        set_alphabet(ALNUM_POOL, 1'b0);
        load_alphabet();
        start_phase(0, 66);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd61);
        pending_values.push_back(32'd62);
        pending_values.push_back(-32'd62);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        wait_block_idle();

        // invalid alphabets: too short, bad character, repeat, no terminator
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0: set_alphabet("7", 1'b1);
                1: set_alphabet("01+3", 1'b0);
                2: set_alphabet("0120", 1'b0);
                default: set_alphabet({ALNUM_POOL, "Zz"}, 1'b0);
            endcase
            load_alphabet();
            start_phase(0, 0);
            pending_values.push_back(32'h8000_0000);
            pending_values.push_back($urandom);
            wait_block_idle();
        end

        // hex, then writes to unmapped indexes must leave it alone
        set_alphabet("0123456789abcdef", 1'b0);
        load_alphabet();
        write_cfg(ALPHA_REGS, {$urandom, $urandom});
        write_cfg(CFG_INDEX_TOP, {$urandom, $urandom});
        write_cfg($urandom_range(CFG_INDEX_TOP - 1, ALPHA_REGS + 1), {$urandom, $urandom});
        cfg_valid <= 1'b0;
        start_phase(7, 7);
        pending_values.push_back(32'hDEAD_BEEF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'd255);
        wait_block_idle();

        // backpressure: receiver held off while the sender keeps offering
        set_alphabet("ab", 1'b1);
        load_alphabet();
        start_phase(0, 0);
        for (int i = 0; i < 30; i++)
            pending_values.push_back($urandom);
        pressure_start = 1'b1;
        wait_block_idle();

        // random alphabets under each idle mode
        for (int k = 0; k < 8; k++)
        begin
            case ($urandom_range(3))
                0: alpha = random_alphabet(62);
                1: alpha = random_alphabet($urandom_range(62, 17));
                default: alpha = random_alphabet($urandom_range(16, 2));
            endcase
            set_alphabet(alpha, 1'($urandom_range(1)));
            load_alphabet();
            case (k % 4)
                0: start_phase(0, 0);
                1: start_phase(66, 0);
                2: start_phase(0, 66);
                default: start_phase(7, 7);
            endcase
            for (int i = 0; i < 19; i++)
                pending_values.push_back(random_value());
            wait_block_idle();
        end

        // random alphabet broken by a repeated character
        alpha = random_alphabet($urandom_range(20, 2));
        set_alphabet({alpha, alpha.substr(0, 0)}, 1'b0);
        load_alphabet();
        start_phase(7, 7);
        for (int i = 0; i < 10; i++)
            pending_values.push_back(random_value());
        wait_block_idle();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/itrt_pkg.sv
rtl/core/itrt_alpha_check.sv
rtl/core/itrt_front.sv
rtl/core/itrt_queue.sv
rtl/core/itrt_back.sv
rtl/core/integer_to_radix_text.sv
rtl/core/itrt_checker.sv
bench/tb_top.sv
